// ----- rtl/cnps_pkg.sv -----
`timescale 1ns / 1ps

package cnps_pkg;

  // Curve depth and fixed field widths.
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W        = 32;
  localparam int DX_W           = 31;
  localparam int CNT_W          = 11;
  localparam int PIDX_W         = 10;
  localparam int OP_W           = 2;

  // Width of the shared add/subtract unit. Operands are sign-extended
  // coordinates, the zero-extended dx or earlier sums, and a difference of
  // two coordinate differences still fits.
  localparam int DW = 35;

  // Configuration register indexes (address bit 2 selects the register).
  localparam logic REG_POINTS = 1'b0;
  localparam logic REG_RISING = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_NEAR_X  = 2'd1,
    OP_NEAR_XY = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BS_CHK,
    ST_BS_CMP,
    ST_BS_TOP,
    ST_BS_BOT,
    ST_BS_FIN,
    ST_QM,
    ST_QP,
    ST_LO_CMP,
    ST_HI_ISS,
    ST_HI_CMP,
    ST_SC_ISS,
    ST_SC_X,
    ST_SC_Y,
    ST_LIN_ISS,
    ST_LIN
  } state_t;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic          sub;
    word_t         a;
    word_t         b;
    logic [DW-1:0] c;
  } alu_req_t;

  typedef struct packed {
    word_t         sum;
    logic [DW-1:0] mag;
    logic          neg;
    logic          lt;
  } alu_res_t;

  function automatic word_t sext_coord(input logic [COORD_W-1:0] v);
    sext_coord = {{(DW-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic word_t zext_dx(input logic [DX_W-1:0] v);
    zext_dx = {{(DW-DX_W){1'b0}}, v};
  endfunction

endpackage

// ----- rtl/cnps_mem.sv -----
`timescale 1ns / 1ps

module cnps_mem #(
  parameter int DEPTH = cnps_pkg::MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [cnps_pkg::COORD_W-1:0] wx,
  input  logic [cnps_pkg::COORD_W-1:0] wy,
  input  logic [AW-1:0]                raddr,
  output logic [cnps_pkg::COORD_W-1:0] rx,
  output logic [cnps_pkg::COORD_W-1:0] ry
);

  logic [cnps_pkg::COORD_W-1:0] x_mem [DEPTH];
  logic [cnps_pkg::COORD_W-1:0] y_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[waddr] <= wx;
      y_mem[waddr] <= wy;
    end
    rx <= x_mem[raddr];
    ry <= y_mem[raddr];
  end

endmodule

// ----- rtl/cnps_alu.sv -----
`timescale 1ns / 1ps

module cnps_alu (
  input  cnps_pkg::alu_req_t req,
  output cnps_pkg::alu_res_t res
);

  localparam int DW = cnps_pkg::DW;

  cnps_pkg::word_t sum;
  logic [DW-1:0]   mag;

  // One add/subtract, then the magnitude and its compare with a threshold.
  always_comb begin
    sum = req.sub ? (req.a - req.b) : (req.a + req.b);
    mag = sum[DW-1] ? -sum : sum;
    res.sum = sum;
    res.mag = mag;
    res.neg = sum[DW-1];
    res.lt  = (mag < req.c);
  end

endmodule

// ----- rtl/cnps_ctrl.sv -----
`timescale 1ns / 1ps

module cnps_ctrl #(
  parameter int MAX_POINTS = cnps_pkg::MAX_POINTS_DEF,
  parameter int IW         = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cnps_pkg::OP_W-1:0]    op,
  input  logic [cnps_pkg::PIDX_W-1:0]  point_index,
  input  logic [cnps_pkg::COORD_W-1:0] query_x,
  input  logic [cnps_pkg::DX_W-1:0]    query_dx,
  input  logic [cnps_pkg::COORD_W-1:0] query_y,
  input  logic [cnps_pkg::CNT_W-1:0]   points_in_use,
  input  logic                         x_rising,
  output logic                         busy,
  output logic                         result_valid,
  output logic [cnps_pkg::PIDX_W-1:0]  found_index,
  output logic                         mem_we,
  output logic [IW-1:0]                mem_waddr,
  output logic [IW-1:0]                rd_addr,
  input  logic [cnps_pkg::COORD_W-1:0] rd_x,
  input  logic [cnps_pkg::COORD_W-1:0] rd_y,
  output cnps_pkg::alu_req_t           alu_req,
  input  cnps_pkg::alu_res_t           alu_res
);

  localparam int DW = cnps_pkg::DW;
  localparam int PW = cnps_pkg::PIDX_W;
  localparam int CW = cnps_pkg::CNT_W;

  cnps_pkg::state_t state, state_next;

  logic                         result_valid_next;
  logic [PW-1:0]                found_index_next;

  logic [cnps_pkg::COORD_W-1:0] qx, qx_next;
  logic [cnps_pkg::COORD_W-1:0] qy, qy_next;
  logic [cnps_pkg::DX_W-1:0]    dx, dx_next;
  logic                         want_xy, want_xy_next;
  logic [IW-1:0]                last, last_next;
  logic [IW-1:0]                lo, lo_next;
  logic [IW-1:0]                hi, hi_next;
  logic [IW-1:0]                mid, mid_next;
  logic [IW-1:0]                idx, idx_next;
  logic [IW-1:0]                best, best_next;
  logic [DW-1:0]                bd, bd_next;
  cnps_pkg::word_t              acc_a, acc_a_next;
  cnps_pkg::word_t              acc_b, acc_b_next;
  logic                         pass, pass_next;
  logic                         first, first_next;

  logic                         fin;
  logic [IW-1:0]                fin_idx;
  logic [IW-1:0]                last_in;
  logic [CW-1:0]                pin_m1;
  logic [IW:0]                  lo_p1;
  logic [IW:0]                  mid_sum;
  logic [IW-1:0]                bracket_pick;
  logic                         take;

  assign busy = (state != cnps_pkg::ST_IDLE);

  // Index of the last point in use, clamped to the store depth.
  always_comb begin
    pin_m1 = points_in_use - CW'(1);
    if (points_in_use == '0) begin
      last_in = '0;
    end else if (32'(points_in_use) > 32'(MAX_POINTS)) begin
      last_in = IW'(MAX_POINTS - 1);
    end else begin
      last_in = IW'(pin_m1);
    end
  end

  always_comb begin
    state_next        = state;
    result_valid_next = 1'b0;
    found_index_next  = found_index;
    qx_next           = qx;
    qy_next           = qy;
    dx_next           = dx;
    want_xy_next      = want_xy;
    last_next         = last;
    lo_next           = lo;
    hi_next           = hi;
    mid_next          = mid;
    idx_next          = idx;
    best_next         = best;
    bd_next           = bd;
    acc_a_next        = acc_a;
    acc_b_next        = acc_b;
    pass_next         = pass;
    first_next        = first;
    fin               = 1'b0;
    fin_idx           = best;
    take              = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = IW'(point_index);
    rd_addr           = idx;
    lo_p1             = {1'b0, lo} + (IW+1)'(1);
    mid_sum           = {1'b0, lo} + {1'b0, hi};
    bracket_pick      = alu_res.neg ? hi : lo;

    alu_req.sub = 1'b1;
    alu_req.a   = cnps_pkg::sext_coord(qx);
    alu_req.b   = cnps_pkg::sext_coord(rd_x);
    alu_req.c   = bd;

    unique case (state)
      cnps_pkg::ST_IDLE: begin
        if (start) begin
          qx_next      = query_x;
          qy_next      = query_y;
          dx_next      = query_dx;
          last_next    = last_in;
          lo_next      = '0;
          hi_next      = last_in;
          want_xy_next = (op == cnps_pkg::OP_NEAR_XY);
          priority if (op == cnps_pkg::OP_WRITE) begin
            mem_we = (32'(point_index) < 32'(MAX_POINTS));
          end else if (op == cnps_pkg::OP_NEAR_X || op == cnps_pkg::OP_NEAR_XY) begin
            if (x_rising) begin
              state_next = cnps_pkg::ST_BS_CHK;
            end else if (op == cnps_pkg::OP_NEAR_XY) begin
              state_next = cnps_pkg::ST_SC_ISS;
            end else begin
              state_next = cnps_pkg::ST_LIN_ISS;
            end
          end else begin
            state_next = cnps_pkg::ST_IDLE;
          end
        end
      end

      // Binary search: lo and hi hold the bracket.
      cnps_pkg::ST_BS_CHK: begin
        if (lo_p1 < {1'b0, hi}) begin
          mid_next   = mid_sum[IW:1];
          rd_addr    = mid_sum[IW:1];
          state_next = cnps_pkg::ST_BS_CMP;
        end else begin
          rd_addr    = hi;
          state_next = cnps_pkg::ST_BS_TOP;
        end
      end

      cnps_pkg::ST_BS_CMP: begin
        if (alu_res.neg) begin
          hi_next = mid;
        end else begin
          lo_next = mid;
        end
        state_next = cnps_pkg::ST_BS_CHK;
      end

      cnps_pkg::ST_BS_TOP: begin
        alu_req.a  = cnps_pkg::sext_coord(rd_x);
        alu_req.b  = cnps_pkg::sext_coord(qx);
        acc_a_next = alu_res.sum;
        rd_addr    = lo;
        state_next = cnps_pkg::ST_BS_BOT;
      end

      cnps_pkg::ST_BS_BOT: begin
        acc_b_next = alu_res.sum;
        state_next = cnps_pkg::ST_BS_FIN;
      end

      cnps_pkg::ST_BS_FIN: begin
        alu_req.a = acc_a;
        alu_req.b = acc_b;
        if (want_xy) begin
          lo_next    = bracket_pick;
          hi_next    = bracket_pick;
          state_next = cnps_pkg::ST_QM;
        end else begin
          fin     = 1'b1;
          fin_idx = bracket_pick;
        end
      end

      // Window limits query_x - dx and query_x + dx.
      cnps_pkg::ST_QM: begin
        alu_req.b  = cnps_pkg::zext_dx(dx);
        acc_a_next = alu_res.sum;
        state_next = cnps_pkg::ST_QP;
      end

      cnps_pkg::ST_QP: begin
        alu_req.sub = 1'b0;
        alu_req.b   = cnps_pkg::zext_dx(dx);
        acc_b_next  = alu_res.sum;
        rd_addr     = lo;
        state_next  = (lo != '0) ? cnps_pkg::ST_LO_CMP : cnps_pkg::ST_HI_ISS;
      end

      cnps_pkg::ST_LO_CMP: begin
        alu_req.a = acc_a;
        rd_addr   = lo - IW'(1);
        if (alu_res.neg) begin
          lo_next    = lo - IW'(1);
          state_next = (lo == IW'(1)) ? cnps_pkg::ST_HI_ISS : cnps_pkg::ST_LO_CMP;
        end else begin
          state_next = cnps_pkg::ST_HI_ISS;
        end
      end

      cnps_pkg::ST_HI_ISS: begin
        rd_addr    = hi;
        state_next = (hi != last) ? cnps_pkg::ST_HI_CMP : cnps_pkg::ST_SC_ISS;
      end

      cnps_pkg::ST_HI_CMP: begin
        alu_req.a = cnps_pkg::sext_coord(rd_x);
        alu_req.b = acc_b;
        rd_addr   = hi + IW'(1);
        if (alu_res.neg) begin
          hi_next    = hi + IW'(1);
          state_next = (hi + IW'(1) == last) ? cnps_pkg::ST_SC_ISS : cnps_pkg::ST_HI_CMP;
        end else begin
          state_next = cnps_pkg::ST_SC_ISS;
        end
      end

      // Window scan: an x test then a y test per point.
      cnps_pkg::ST_SC_ISS: begin
        rd_addr    = lo;
        idx_next   = lo;
        best_next  = lo;
        bd_next    = '1;
        first_next = 1'b1;
        state_next = cnps_pkg::ST_SC_X;
      end

      cnps_pkg::ST_SC_X: begin
        alu_req.c  = cnps_pkg::zext_dx(dx);
        pass_next  = first | alu_res.lt;
        state_next = cnps_pkg::ST_SC_Y;
      end

      cnps_pkg::ST_SC_Y: begin
        alu_req.a = cnps_pkg::sext_coord(qy);
        alu_req.b = cnps_pkg::sext_coord(rd_y);
        take      = pass & alu_res.lt;
        if (take) begin
          bd_next   = alu_res.mag;
          best_next = idx;
        end
        if (idx == hi) begin
          fin     = 1'b1;
          fin_idx = take ? idx : best;
        end else begin
          idx_next   = idx + IW'(1);
          rd_addr    = idx + IW'(1);
          first_next = 1'b0;
          state_next = cnps_pkg::ST_SC_X;
        end
      end

      // Linear nearest-x scan, one point per cycle.
      cnps_pkg::ST_LIN_ISS: begin
        rd_addr    = '0;
        idx_next   = '0;
        best_next  = '0;
        bd_next    = '1;
        state_next = cnps_pkg::ST_LIN;
      end

      cnps_pkg::ST_LIN: begin
        take = alu_res.lt;
        if (take) begin
          bd_next   = alu_res.mag;
          best_next = idx;
        end
        if (idx == last) begin
          fin     = 1'b1;
          fin_idx = take ? idx : best;
        end else begin
          idx_next = idx + IW'(1);
          rd_addr  = idx + IW'(1);
        end
      end

      default: begin
        state_next = cnps_pkg::ST_IDLE;
      end
    endcase

    if (fin) begin
      result_valid_next = 1'b1;
      found_index_next  = PW'(fin_idx);
      state_next        = cnps_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cnps_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    found_index <= found_index_next;
    qx          <= qx_next;
    qy          <= qy_next;
    dx          <= dx_next;
    want_xy     <= want_xy_next;
    last        <= last_next;
    lo          <= lo_next;
    hi          <= hi_next;
    mid         <= mid_next;
    idx         <= idx_next;
    best        <= best_next;
    bd          <= bd_next;
    acc_a       <= acc_a_next;
    acc_b       <= acc_b_next;
    pass        <= pass_next;
    first       <= first_next;
  end

  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state != cnps_pkg::ST_IDLE))
    else $error("result strobe without a finished search");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == cnps_pkg::OP_NEAR_X || op == cnps_pkg::OP_NEAR_XY))
      |=> busy)
    else $error("accepted query did not start a search");

  a_bracket: assert property (@(posedge clk) disable iff (rst)
    (state == cnps_pkg::ST_BS_CMP) |-> (lo < mid && mid < hi))
    else $error("binary search probe outside its bracket");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    (state == cnps_pkg::ST_SC_X || state == cnps_pkg::ST_SC_Y)
      |-> (lo <= idx && idx <= hi && hi <= last))
    else $error("window scan index outside the window");

endmodule

// ----- rtl/curve_nearest_point_search_top.sv -----
`timescale 1ns / 1ps
// Nearest-x, sorted curve: binary search; nearest-x, unsorted curve: linear scan of every point.
// Nearest-xy, unsorted: a window scan over the whole curve.
// Nearest-xy, sorted: the search above, the window limits, the window-edge compares (every widening
// step and at most one failing compare per side), then an x and a y test per window point.
// A point write leaves busy low. One item at a time: one read port, one adder.
// Reset (rst, synchronous): points_in_use = 1, x_rising = 0, idle; the stores are not cleared.

module curve_nearest_point_search_top #(
  parameter int MAX_POINTS = cnps_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,

  // Command channel. A beat is taken when start is high and busy is low.
  input  logic                         start,
  output logic                         busy,
  input  logic [cnps_pkg::OP_W-1:0]    op,
  input  logic [cnps_pkg::PIDX_W-1:0]  point_index,
  input  logic [cnps_pkg::COORD_W-1:0] point_x,
  input  logic [cnps_pkg::COORD_W-1:0] point_y,
  input  logic [cnps_pkg::COORD_W-1:0] query_x,
  input  logic [cnps_pkg::DX_W-1:0]    query_dx,
  input  logic [cnps_pkg::COORD_W-1:0] query_y,

  // Result beat: valid for exactly one cycle, cannot be held off.
  output logic                         result_valid,
  output logic [cnps_pkg::PIDX_W-1:0]  found_index,

  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int IW = $clog2(MAX_POINTS);

  logic [cnps_pkg::CNT_W-1:0]   points_in_use;
  logic                         x_rising;
  logic                         cfg_wr;

  logic                         mem_we;
  logic [IW-1:0]                mem_waddr;
  logic [IW-1:0]                rd_addr;
  logic [cnps_pkg::COORD_W-1:0] rd_x;
  logic [cnps_pkg::COORD_W-1:0] rd_y;

  cnps_pkg::alu_req_t           alu_req;
  cnps_pkg::alu_res_t           alu_res;

  // The register port never waits. Address bit 2 picks the register:
  // byte address 0 holds the point count and byte address 4 the sorted flag.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= cnps_pkg::CNT_W'(1);
      x_rising      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        cnps_pkg::REG_POINTS: points_in_use <= pwdata[cnps_pkg::CNT_W-1:0];
        cnps_pkg::REG_RISING: x_rising      <= pwdata[0];
        default:              x_rising      <= x_rising;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      cnps_pkg::REG_POINTS: prdata = 32'(points_in_use);
      cnps_pkg::REG_RISING: prdata = 32'(x_rising);
      default:              prdata = '0;
    endcase
  end

  // Point store: x and y side by side, one write and one registered read
  // per cycle, both read at the same index.
  cnps_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wx    (point_x),
    .wy    (point_y),
    .raddr (rd_addr),
    .rx    (rd_x),
    .ry    (rd_y)
  );

  // The one add/subtract unit with magnitude and threshold compare. Every
  // coordinate compare, window-limit computation and distance test goes through it.
  cnps_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Sequencer: binary search on a sorted curve or linear scan for the nearest x. Nearest-xy queries
  // skip the linear scan and end in the window scan on y, after the search and window widening if sorted.
  cnps_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .IW         (IW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .point_index   (point_index),
    .query_x       (query_x),
    .query_dx      (query_dx),
    .query_y       (query_y),
    .points_in_use (points_in_use),
    .x_rising      (x_rising),
    .busy          (busy),
    .result_valid  (result_valid),
    .found_index   (found_index),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .rd_addr       (rd_addr),
    .rd_x          (rd_x),
    .rd_y          (rd_y),
    .alu_req       (alu_req),
    .alu_res       (alu_res)
  );

endmodule

// ----- dv/curve_nearest_point_search_top_tb.sv -----
`timescale 1ns / 1ps

module curve_nearest_point_search_top_tb;

  localparam int OP_W    = cnps_pkg::OP_W;
  localparam int PIDX_W  = cnps_pkg::PIDX_W;
  localparam int COORD_W = cnps_pkg::COORD_W;
  localparam int DX_W    = cnps_pkg::DX_W;
  localparam int CNT_W   = cnps_pkg::CNT_W;

  // Q16.16 constants used by the directed beats.
  localparam int ONE = 65536;
  localparam int MIN_C = int'(32'h8000_0000);
  localparam int MAX_C = int'(32'h7FFF_FFFF);
  localparam logic [DX_W-1:0] DX_MAX = 31'h7FFF_FFFF;

  // Op 3 is not part of the enum; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Register byte addresses: register i lives at 4*i.
  localparam logic [2:0] ADDR_POINTS = {cnps_pkg::REG_POINTS, 2'b00};
  localparam logic [2:0] ADDR_RISING = {cnps_pkg::REG_RISING, 2'b00};

  // The slowest query is a nearest-xy query on a sorted curve whose window covers all 1024
  // points, with nothing accepted meanwhile. The limit lies well above its duration.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2100;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [PIDX_W-1:0]  pt_index;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] qx;
    logic [DX_W-1:0]    dx;
    logic [COORD_W-1:0] qy;
  } cmd_t;

  // All block inputs start at known values.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    op = '0;
  logic [PIDX_W-1:0]  point_index = '0;
  logic [COORD_W-1:0] point_x = '0;
  logic [COORD_W-1:0] point_y = '0;
  logic [COORD_W-1:0] query_x = '0;
  logic [DX_W-1:0]    query_dx = '0;
  logic [COORD_W-1:0] query_y = '0;
  logic               result_valid;
  logic [PIDX_W-1:0]  found_index;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow copy of the curve and of the two registers.
  int                 curve_x [1024];
  int                 curve_y [1024];
  logic [CNT_W-1:0]   points_cfg = 11'd1;
  logic               rising_cfg = 1'b0;

  // Found indexes still owed by the block, oldest first.
  logic [PIDX_W-1:0]  found_index_q [$];
  logic [PIDX_W-1:0]  want_index;

  int                 err_cnt = 0;
  int                 stall_cnt = 0;
  bit                 quiet = 1'b0;   // when set, the sender inserts no gaps

  curve_nearest_point_search_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .point_index  (point_index),
    .point_x      (point_x),
    .point_y      (point_y),
    .query_x      (query_x),
    .query_dx     (query_dx),
    .query_y      (query_y),
    .result_valid (result_valid),
    .found_index  (found_index),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Search predictor
  // ---------------------------------------------------------------------

  function automatic longint abs_diff(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // A count of zero behaves as one point, anything past the store depth
  // behaves as the full store.
  function automatic int live_points();
    if (points_cfg == 0) return 1;
    if (points_cfg > 1024) return 1024;
    return int'(points_cfg);
  endfunction

  // Sorted curve: bisection that keeps bot <= target < top, then the closer
  // end wins, the lower index on a tie. Unsorted: the first minimum wins.
  function automatic int nearest_x_index(input longint qx, input int n);
    int top, bot, mid, best;
    longint bd, d;
    if (rising_cfg) begin
      top = n - 1;
      bot = 0;
      while (bot + 1 < top) begin
        mid = (top + bot) / 2;
        if (qx < longint'(curve_x[mid])) top = mid;
        else bot = mid;
      end
      if (longint'(curve_x[top]) - qx < qx - longint'(curve_x[bot])) return top;
      return bot;
    end
    best = 0;
    bd = abs_diff(qx, curve_x[0]);
    for (int i = 1; i < n; i++) begin
      d = abs_diff(qx, curve_x[i]);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    return best;
  endfunction

  // The window grows outward from the nearest-x index on a sorted curve and
  // covers the whole curve otherwise. Its first index is the fallback answer
  // even when that point lies outside the strict x window.
  function automatic int nearest_xy_index(input longint qx, input longint dx,
                                          input longint qy, input int n);
    int lo, hi, best, ctr;
    longint bd, d;
    lo = 0;
    hi = n - 1;
    if (rising_cfg) begin
      ctr = nearest_x_index(qx, n);
      lo = ctr;
      while (lo > 0 && qx - dx < longint'(curve_x[lo])) lo--;
      hi = ctr;
      while (hi < n - 1 && qx + dx > longint'(curve_x[hi])) hi++;
    end
    best = lo;
    bd = abs_diff(qy, curve_y[lo]);
    for (int i = lo + 1; i <= hi; i++) begin
      if (abs_diff(qx, curve_x[i]) < dx) begin
        d = abs_diff(qy, curve_y[i]);
        if (d < bd) begin
          bd = d;
          best = i;
        end
      end
    end
    return best;
  endfunction

  // Applies one accepted beat to the shadow curve and queues its answer.
  task automatic predict_beat(input cmd_t c);
    longint qx, dx, qy;
    int n;
    qx = longint'(signed'(c.qx));
    dx = longint'(c.dx);
    qy = longint'(signed'(c.qy));
    n = live_points();
    case (c.op)
      cnps_pkg::OP_WRITE: begin
        curve_x[c.pt_index] = int'(c.px);
        curve_y[c.pt_index] = int'(c.py);
      end
      cnps_pkg::OP_NEAR_X:
        found_index_q.push_back(PIDX_W'(nearest_x_index(qx, n)));
      cnps_pkg::OP_NEAR_XY:
        found_index_q.push_back(PIDX_W'(nearest_xy_index(qx, dx, qy, n)));
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------

  // Outputs are read in the active region right after the edge, so they
  // still hold the values that the edge captured.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        if (found_index_q.size() == 0) begin
          $error("found_index: no result expected, got %0d", found_index);
          err_cnt++;
        end else begin
          want_index = found_index_q.pop_front();
          if (found_index !== want_index) begin
            $error("found_index: expected %0d, got %0d", want_index, found_index);
            err_cnt++;
          end
        end
      end
      if ((start && !busy) || result_valid || (psel && penable && pwrite)) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= WATCHDOG_LIMIT) begin
        $error("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  function automatic cmd_t write_cmd(input int idx, input int x, input int y);
    cmd_t c;
    c = '{op: cnps_pkg::OP_WRITE, pt_index: PIDX_W'(idx), px: x, py: y,
          qx: '0, dx: '0, qy: '0};
    return c;
  endfunction

  function automatic cmd_t query_cmd(input logic [OP_W-1:0] code, input int x,
                                     input logic [DX_W-1:0] half_w, input int y);
    cmd_t c;
    c = '{op: code, pt_index: '0, px: '0, py: '0, qx: x, dx: half_w, qy: y};
    return c;
  endfunction

  // Sends one command beat. Called at a rising edge; returns at the edge
  // that accepted it, leaving start high. The next call either presents a
  // new beat at once or lowers start first, so start never gets two
  // assignments in one time step.
  task automatic issue_cmd(input cmd_t c);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    op          <= c.op;
    point_index <= c.pt_index;
    point_x     <= c.px;
    point_y     <= c.py;
    query_x     <= c.qx;
    query_dx    <= c.dx;
    query_y     <= c.qy;
    do @(posedge clk); while (busy !== 1'b0);
    predict_beat(c);
  endtask

  // The sender stops until every owed result has arrived.
  task automatic hold_for_results();
    if (found_index_q.size() != 0) begin
      start <= 1'b0;
      while (found_index_q.size() != 0) @(posedge clk);
    end
  endtask

  // A write or an ignored op gives no result, so after the last result the
  // task also waits until the block reports itself not busy.
  task automatic wait_idle();
    start <= 1'b0;
    while (found_index_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Setup phase, then access phase; the register takes the value at the
  // edge where the access phase sees pready. The bus then goes idle, so a
  // second write starts in a later time step.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (addr)
      ADDR_POINTS: points_cfg = data[CNT_W-1:0];
      ADDR_RISING: rising_cfg = data[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are random; only the register's own bits count.
  task automatic configure_curve(input int count, input bit rising);
    logic [31:0] data;
    wait_idle();
    data = ($urandom << CNT_W) | 32'(count & 'h7FF);
    write_reg(ADDR_POINTS, data);
    data = ($urandom & ~32'd1) | 32'(rising);
    write_reg(ADDR_RISING, data);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0: return MIN_C;
      1: return MAX_C;
      2, 3: return (int'($urandom_range(0, 4000)) - 2000) <<< 14;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int rand_y();
    if ($urandom_range(0, 1) == 0) return rand_coord();
    return int'($urandom_range(0, 3)) <<< 16;   // few distinct values, many ties
  endfunction

  // Writes points 0..n-1. X is spread over the full range, packed closely
  // with duplicates, or a mix of extremes; sorted when ordered is set.
  task automatic load_curve(input int n, input bit ordered);
    int xs[$];
    int base, mode;
    mode = $urandom_range(0, 2);
    base = (int'($urandom_range(0, 4000)) - 2000) <<< 14;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: xs.push_back(int'($urandom));
        1: xs.push_back(base + (int'($urandom_range(0, 3 * n)) <<< 14));
        default: xs.push_back(rand_coord());
      endcase
    end
    if (ordered) xs.sort();
    for (int i = 0; i < n; i++) issue_cmd(write_cmd(i, xs[i], rand_y()));
  endtask

  // Random beat over a curve of n loaded points. Queries aim at stored
  // points, midpoints between neighbours and window edges so that ties and
  // boundary cases come up often. On a sorted curve most writes keep x.
  function automatic cmd_t random_cmd(input int n, input bit keep_order);
    cmd_t c;
    int i, j, r;
    longint m;
    c.pt_index = PIDX_W'($urandom);
    c.px = $urandom;
    c.py = $urandom;
    c.qx = $urandom;
    c.dx = DX_W'($urandom);
    c.qy = $urandom;
    i = $urandom_range(0, n - 1);
    j = $urandom_range(0, n - 1);
    r = $urandom_range(0, 19);
    if (r < 3) c.op = cnps_pkg::OP_WRITE;
    else if (r < 11) c.op = cnps_pkg::OP_NEAR_X;
    else if (r < 19) c.op = cnps_pkg::OP_NEAR_XY;
    else c.op = OP_UNUSED;
    if (c.op == cnps_pkg::OP_WRITE) begin
      if ($urandom_range(0, 9) != 0) c.pt_index = PIDX_W'(i);
      c.px = (keep_order && $urandom_range(0, 3) != 0) ? curve_x[c.pt_index] : rand_coord();
      c.py = rand_y();
      return c;
    end
    case ($urandom_range(0, 5))
      0: c.qx = curve_x[i];
      1: c.qx = curve_x[i] + int'($urandom_range(0, 6)) - 3;
      2: begin
        if (i < n - 1) begin
          m = (longint'(curve_x[i]) + longint'(curve_x[i + 1])) / 2;
          c.qx = m[31:0];
        end else begin
          c.qx = rand_coord();
        end
      end
      3: c.qx = rand_coord();
      4: c.qx = $urandom_range(0, 1) ? MIN_C : MAX_C;
      default: c.qx = curve_x[i] + int'($urandom_range(0, 65535)) - 32768;
    endcase
    case ($urandom_range(0, 5))
      0: c.dx = '0;
      1: c.dx = DX_MAX;
      2: ;
      3, 4: begin
        m = abs_diff(curve_x[i], curve_x[j]);
        if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
        c.dx = DX_W'(m + longint'($urandom_range(0, 2)) - 1);
      end
      default: c.dx = DX_W'($urandom_range(0, 1 << 20));
    endcase
    case ($urandom_range(0, 2))
      0: c.qy = curve_y[j];
      1: c.qy = curve_y[j] + int'($urandom_range(0, 4)) - 2;
      default: c.qy = rand_coord();
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset leaves one live point. Coordinate extremes, the top write index,
  // both window extremes, the ignored op and a zero point count.
  task automatic test_single_point();
    cmd_t c;
    issue_cmd(write_cmd(0, MIN_C, MAX_C));
    issue_cmd(write_cmd(1023, MAX_C, MIN_C));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, MAX_C, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, MAX_C, DX_MAX, MIN_C));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, MIN_C, '0, MAX_C));
    c = write_cmd(0, 0, 0);
    c.op = OP_UNUSED;
    issue_cmd(c);
    configure_curve(0, 1);
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, 0, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, MIN_C, DX_MAX, 0));
  endtask

  // Four points with a duplicated x and a tie in y. Covers ties in the
  // bisection, the strict window test at zero and full width, a curve that
  // stops rising while marked as rising, and the first-minimum rule.
  task automatic test_small_curve();
    configure_curve(4, 1);
    issue_cmd(write_cmd(0, -2 * ONE, 5 * ONE));
    issue_cmd(write_cmd(1, 0, -ONE));
    issue_cmd(write_cmd(2, 0, 2 * ONE));
    issue_cmd(write_cmd(3, 3 * ONE, -ONE));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, -ONE, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, 3 * ONE / 2, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, MIN_C, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, 0, DX_W'(4 * ONE), -ONE));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, 0, '0, 2 * ONE));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, MAX_C, DX_MAX, MAX_C));
    issue_cmd(write_cmd(3, -5 * ONE, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, ONE, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, ONE, DX_W'(ONE), 0));
    configure_curve(4, 0);
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, 0, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, -ONE, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, 0, DX_MAX, -ONE));
  endtask

  // Loads a long curve back to back, then searches it sorted and unsorted.
  task automatic test_large_curve();
    configure_curve(256, 1);
    quiet = 1'b1;
    load_curve(256, 1'b1);
    quiet = 1'b0;
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, MIN_C, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, curve_x[117] + 1, '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, curve_x[100], 31'h0010_0000, curve_y[102]));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, 0, DX_MAX, MAX_C));
    configure_curve(256, 0);
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_X, curve_x[255], '0, 0));
    issue_cmd(query_cmd(cnps_pkg::OP_NEAR_XY, curve_x[10], DX_MAX, curve_y[200]));
  endtask

  // Random traffic over a series of register settings. Each setting reloads
  // the live points first, so no query reads a point that was never written.
  task automatic test_random_settings();
    int pts_tab [13] = '{2, 2, 3, 5, 8, 16, 16, 31, 64, 0, 1, 9, 40};
    bit rise_tab [13] = '{1, 0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 1};
    bit order_tab [13] = '{1, 0, 1, 0, 1, 1, 1, 0, 0, 1, 0, 1, 1};
    int n, ph, k;
    for (ph = 0; ph < 13; ph++) begin
      configure_curve(pts_tab[ph], rise_tab[ph]);
      n = live_points();
      load_curve(n, order_tab[ph]);
      for (k = 0; k < 8; k++) begin
        if ($urandom_range(0, 29) == 0) quiet = !quiet;
        if (k == 4 || $urandom_range(0, 39) == 0) hold_for_results();
        issue_cmd(random_cmd(n, order_tab[ph] && rise_tab[ph]));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_point();
    test_small_curve();
    test_large_curve();
    test_random_settings();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && found_index_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
